// ===== hw/rtl/conveyor_size_sorter_fsm_core_assert.svh =====
// Assertion macros for the conveyor sorter checker
`ifndef CONVEYOR_SIZE_SORTER_FSM_CORE_ASSERT_SVH
`define CONVEYOR_SIZE_SORTER_FSM_CORE_ASSERT_SVH
`define CSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hw/rtl/css_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the conveyor size sorter.
// ----------------------------------------------------------------------------
package css_pkg;
   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0, MODE_READY = 3'd1, MODE_RUN = 3'd2, MODE_WAIT = 3'd3,
      MODE_SETTLE = 3'd4, MODE_EVAL = 3'd5, MODE_PAUSE = 3'd6, MODE_REPORT = 3'd7
   } mode_type;

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_CFG    = 3'd1;
   localparam logic [2:0] CMD_START  = 3'd2;
   localparam logic [2:0] CMD_PAUSE  = 3'd3;
   localparam logic [2:0] CMD_RESET  = 3'd4;
   localparam logic [2:0] CMD_IR     = 3'd5;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_SEEN     = 3'd1;
   localparam logic [2:0] EV_LOST     = 3'd2;
   localparam logic [2:0] EV_ACCEPT   = 3'd3;
   localparam logic [2:0] EV_REJECT   = 3'd4;
   localparam logic [2:0] EV_EXPIRED  = 3'd5;
   localparam logic [2:0] EV_REPORT   = 3'd6;

   localparam logic [2:0] REG_QUOTA_S   = 3'd0;
   localparam logic [2:0] REG_QUOTA_M   = 3'd1;
   localparam logic [2:0] REG_QUOTA_L   = 3'd2;
   localparam logic [2:0] REG_LIMIT     = 3'd3;
   localparam logic [2:0] REG_SM_BOUND  = 3'd4;
   localparam logic [2:0] REG_ML_BOUND  = 3'd5;
   localparam logic [2:0] REG_DARK      = 3'd6;
   localparam logic [2:0] REG_TIMEOUT   = 3'd7;

   localparam int BTN_LOCK   = 300;
   localparam int IR_LOCK    = 1200;
   localparam int LAMP_HOLD  = 500;
   localparam int FLASH_HOLD = 200;
   localparam int SECOND_MS  = 1000;
   localparam int BLINK_MS   = 250;
   localparam int SETTLE_MS  = 300;

   // one result word as queued toward the back end
   typedef struct packed {
      logic [2:0]  mode;
      logic        status_lamp;
      logic [1:0]  size_lamp;
      logic        reject_lamp;
      logic [2:0]  event_res;
      logic [1:0]  size_class;
      logic [15:0] accepted_count;
      logic [15:0] rejected_count;
      logic [15:0] lost_count;
      logic [15:0] elapsed_s;
      logic        last;
   } word_type;

   // queue status seen by the front
   typedef struct packed {
      logic room;
      logic empty;
   } qstat_type;
endpackage
`default_nettype wire

// ===== hw/rtl/css_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_front
// Takes items, runs the sorter state machine, pushes result words.
// A report item pushes three words, the later two while the front is busy and the queue has room.
// ----------------------------------------------------------------------------
module css_front #(
   parameter int COUNT_WIDTH = 16,
   parameter int MS_WIDTH    = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_cmd,
   input  wire logic [11:0]           req_light_sample,
   input  wire logic [11:0]           req_size_sample,
   input  wire logic                  csr_valid,
   input  wire logic [2:0]            csr_index,
   input  wire logic [15:0]           csr_data,
   input  wire css_pkg::qstat_type    qstat,
   output logic                       push,
   output css_pkg::word_type          push_word
);
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [MS_WIDTH-1:0] BTN = MS_WIDTH'(css_pkg::BTN_LOCK);
   localparam logic [MS_WIDTH-1:0] IRL = MS_WIDTH'(css_pkg::IR_LOCK);
   localparam logic [MS_WIDTH-1:0] LHD = MS_WIDTH'(css_pkg::LAMP_HOLD);
   localparam logic [MS_WIDTH-1:0] FHD = MS_WIDTH'(css_pkg::FLASH_HOLD);
   localparam logic [MS_WIDTH-1:0] STL = MS_WIDTH'(css_pkg::SETTLE_MS);
   localparam logic [9:0] SEC_LAST = 10'(css_pkg::SECOND_MS - 1);
   localparam logic [7:0] BLK_LAST = 8'(css_pkg::BLINK_MS - 1);

   logic [15:0] q_s_ff, q_m_ff, q_l_ff, lim_ff, tmo_ff;
   logic [11:0] b1_ff, b2_ff, dark_ff;
   css_pkg::mode_type mode_ff, mode_in;
   logic [MS_WIDTH-1:0] ms_ff, ms_in, ph_ff, ph_in, loff_ff, loff_in;
   logic [MS_WIDTH-1:0] lp_ff [3];
   logic [MS_WIDTH-1:0] lp_in [3];
   logic [MS_WIDTH-1:0] ir_ff, ir_in;
   logic [9:0] sec_ff, sec_in;        // ms_counter mod 1000
   logic [7:0] blk_ff, blk_in;        // ms_counter mod 250
   logic blink_ff, blink_in;          // bit 0 of ms_counter / 250
   logic [15:0] el_ff, el_in;
   logic [COUNT_WIDTH-1:0] acc_ff [3];
   logic [COUNT_WIDTH-1:0] acc_in [3];
   logic [COUNT_WIDTH-1:0] rej_ff [3];
   logic [COUNT_WIDTH-1:0] rej_in [3];
   logic [COUNT_WIDTH-1:0] lost_ff, lost_in;
   logic lact_ff, lact_in, rl_ff, rl_in;
   logic [1:0] sl_ff, sl_in;
   logic [1:0] rep_ff, rep_in;        // report lines still to push after first
   logic busy;
   logic take;
   logic [2:0] ev;
   logic [1:0] cls, c;
   logic [COUNT_WIDTH-1:0] ca, cr;
   logic [15:0] q;
   logic [MS_WIDTH-1:0] msn;
   logic act_n, stat;

   function automatic logic [15:0] clamp(input logic [COUNT_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
   endfunction

   assign busy = (rep_ff != 2'd0);
   assign req_ready = qstat.room && !busy;
   assign take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_s_ff <= '0; q_m_ff <= '0; q_l_ff <= '0; lim_ff <= '0;
         b1_ff <= 12'd1365; b2_ff <= 12'd2730; dark_ff <= 12'd2500;
         tmo_ff <= 16'd3000;
      end else if (csr_valid) begin
         unique case (csr_index)
            css_pkg::REG_QUOTA_S:  q_s_ff <= csr_data;
            css_pkg::REG_QUOTA_M:  q_m_ff <= csr_data;
            css_pkg::REG_QUOTA_L:  q_l_ff <= csr_data;
            css_pkg::REG_LIMIT:    lim_ff <= csr_data;
            css_pkg::REG_SM_BOUND: b1_ff <= csr_data[11:0];
            css_pkg::REG_ML_BOUND: b2_ff <= csr_data[11:0];
            css_pkg::REG_DARK:     dark_ff <= csr_data[11:0];
            css_pkg::REG_TIMEOUT:  tmo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= css_pkg::MODE_IDLE;
         ms_ff <= '0; ph_ff <= '0; loff_ff <= '0; ir_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            lp_ff[i] <= '0; acc_ff[i] <= '0; rej_ff[i] <= '0;
         end
         sec_ff <= '0; blk_ff <= '0; blink_ff <= 1'b0; el_ff <= '0;
         lost_ff <= '0; lact_ff <= 1'b0; rl_ff <= 1'b0; sl_ff <= '0;
         rep_ff <= '0;
      end else begin
         mode_ff <= mode_in; ms_ff <= ms_in; ph_ff <= ph_in; loff_ff <= loff_in;
         ir_ff <= ir_in;
         for (int i = 0; i < 3; i++) begin
            lp_ff[i] <= lp_in[i]; acc_ff[i] <= acc_in[i]; rej_ff[i] <= rej_in[i];
         end
         sec_ff <= sec_in; blk_ff <= blk_in; blink_ff <= blink_in; el_ff <= el_in;
         lost_ff <= lost_in; lact_ff <= lact_in; rl_ff <= rl_in; sl_ff <= sl_in;
         rep_ff <= rep_in;
      end
   end

   function automatic logic is_act(input css_pkg::mode_type m);
      return m == css_pkg::MODE_RUN || m == css_pkg::MODE_WAIT ||
             m == css_pkg::MODE_SETTLE;
   endfunction

   always_comb begin
      mode_in = mode_ff; ms_in = ms_ff; ph_in = ph_ff; loff_in = loff_ff;
      ir_in = ir_ff;
      for (int i = 0; i < 3; i++) begin
         lp_in[i] = lp_ff[i]; acc_in[i] = acc_ff[i]; rej_in[i] = rej_ff[i];
      end
      sec_in = sec_ff; blk_in = blk_ff; blink_in = blink_ff; el_in = el_ff;
      lost_in = lost_ff; lact_in = lact_ff; rl_in = rl_ff; sl_in = sl_ff;
      rep_in = rep_ff;
      ev = css_pkg::EV_NONE; cls = '0; ca = '0; cr = '0;
      act_n = 1'b0; stat = 1'b0;
      push = 1'b0;
      msn = ms_ff + 1'b1;
      c = (req_size_sample < b1_ff) ? 2'd0 : (req_size_sample < b2_ff) ? 2'd1 : 2'd2;
      q = (c == 2'd0) ? q_s_ff : (c == 2'd1) ? q_m_ff : q_l_ff;
      push_word = '0;

      if (busy) begin
         // drain remaining report lines; metrics cleared after the last
         push = qstat.room;
         cls = 2'd3 - rep_ff;
         push_word.mode = css_pkg::MODE_IDLE;
         push_word.event_res = css_pkg::EV_REPORT;
         push_word.size_class = cls;
         push_word.accepted_count = clamp(acc_ff[cls]);
         push_word.rejected_count = clamp(rej_ff[cls]);
         push_word.lost_count = clamp(lost_ff);
         push_word.elapsed_s = el_ff;
         push_word.last = (rep_ff == 2'd1);
         if (qstat.room) begin
            rep_in = rep_ff - 2'd1;
            if (rep_ff == 2'd1) begin
               for (int i = 0; i < 3; i++) begin
                  acc_in[i] = '0; rej_in[i] = '0;
               end
               lost_in = '0; el_in = '0; sl_in = '0; rl_in = 1'b0;
            end
         end
      end else if (take) begin
         push = 1'b1;
         priority case (req_cmd)
            css_pkg::CMD_TICK: begin
               ms_in = msn;
               sec_in = (sec_ff == SEC_LAST) ? 10'd0 : sec_ff + 10'd1;
               if (blk_ff == BLK_LAST) begin
                  blk_in = '0; blink_in = ~blink_ff;
               end else begin
                  blk_in = blk_ff + 8'd1;
               end
               // wrap of ms counter breaks mod-1000 alignment; restart the phase counters at zero
               if (msn == '0) begin
                  sec_in = '0; blk_in = '0; blink_in = 1'b0;
               end
               if (is_act(mode_ff) && sec_in == 10'd0 && el_ff != 16'hFFFF)
                  el_in = el_ff + 16'd1;
               if (lact_ff && msn >= loff_ff) begin
                  sl_in = '0; rl_in = 1'b0; lact_in = 1'b0;
               end
               unique case (mode_ff)
                  css_pkg::MODE_RUN: begin
                     if (lim_ff != 16'd0 && el_in >= lim_ff) begin
                        mode_in = css_pkg::MODE_REPORT; ev = css_pkg::EV_EXPIRED;
                     end
                  end
                  css_pkg::MODE_WAIT: begin
                     if (req_light_sample > dark_ff) begin
                        ph_in = msn; mode_in = css_pkg::MODE_SETTLE;
                        ev = css_pkg::EV_SEEN;
                     end else if (MS_WIDTH'(msn - ph_ff) > MS_WIDTH'(tmo_ff)) begin
                        if (lost_ff != CMAX) lost_in = lost_ff + 1'b1;
                        mode_in = css_pkg::MODE_RUN; ev = css_pkg::EV_LOST;
                     end
                  end
                  css_pkg::MODE_SETTLE: begin
                     if (MS_WIDTH'(msn - ph_ff) > STL) mode_in = css_pkg::MODE_EVAL;
                  end
                  css_pkg::MODE_EVAL: begin
                     if (32'(acc_ff[c]) < 32'(q)) begin
                        if (acc_ff[c] != CMAX) acc_in[c] = acc_ff[c] + 1'b1;
                        rl_in = 1'b0; ev = css_pkg::EV_ACCEPT;
                     end else begin
                        if (rej_ff[c] != CMAX) rej_in[c] = rej_ff[c] + 1'b1;
                        rl_in = 1'b1; ev = css_pkg::EV_REJECT;
                     end
                     sl_in = c + 2'd1; loff_in = msn + LHD; lact_in = 1'b1;
                     cls = c; ca = acc_in[c]; cr = rej_in[c];
                     mode_in = css_pkg::MODE_RUN;
                  end
                  css_pkg::MODE_REPORT: begin
                     ev = css_pkg::EV_REPORT; cls = 2'd0;
                     ca = acc_ff[0]; cr = rej_ff[0];
                     rep_in = 2'd2; mode_in = css_pkg::MODE_IDLE;
                  end
                  default: ;
               endcase
            end
            css_pkg::CMD_CFG: begin
               if (mode_ff == css_pkg::MODE_IDLE) mode_in = css_pkg::MODE_READY;
            end
            css_pkg::CMD_START, css_pkg::CMD_PAUSE, css_pkg::CMD_RESET: begin
               if (MS_WIDTH'(ms_ff - lp_ff[req_cmd[1:0] - 2'd2]) > BTN) begin
                  lp_in[req_cmd[1:0] - 2'd2] = ms_ff;
                  if (req_cmd == css_pkg::CMD_START) begin
                     if (mode_ff == css_pkg::MODE_READY) mode_in = css_pkg::MODE_RUN;
                  end else if (req_cmd == css_pkg::CMD_PAUSE) begin
                     if (is_act(mode_ff)) mode_in = css_pkg::MODE_PAUSE;
                     else if (mode_ff == css_pkg::MODE_PAUSE) mode_in = css_pkg::MODE_RUN;
                  end else begin
                     loff_in = ms_ff + FHD; lact_in = 1'b1; sl_in = '0; rl_in = 1'b0;
                     if (mode_ff == css_pkg::MODE_IDLE || mode_ff == css_pkg::MODE_READY) begin
                        for (int i = 0; i < 3; i++) begin
                           acc_in[i] = '0; rej_in[i] = '0;
                        end
                        lost_in = '0; el_in = '0;
                        mode_in = css_pkg::MODE_IDLE;
                     end else begin
                        mode_in = css_pkg::MODE_REPORT;
                     end
                  end
               end
            end
            css_pkg::CMD_IR: begin
               if (MS_WIDTH'(ms_ff - ir_ff) > IRL) begin
                  ir_in = ms_ff;
                  if (mode_ff == css_pkg::MODE_RUN) begin
                     ph_in = ms_ff; mode_in = css_pkg::MODE_WAIT;
                  end
               end
            end
            default: ;
         endcase
         act_n = is_act(mode_in);
         stat = act_n ? 1'b1 : (mode_in == css_pkg::MODE_PAUSE) ? blink_in : 1'b0;
         push_word.mode = mode_in;
         push_word.status_lamp = stat;
         push_word.event_res = ev;
         push_word.size_class = cls;
         push_word.accepted_count = clamp(ca);
         push_word.rejected_count = clamp(cr);
         if (ev == css_pkg::EV_REPORT) begin
            // report lines show the lamps already cleared
            push_word.size_lamp = '0;
            push_word.reject_lamp = 1'b0;
            push_word.lost_count = clamp(lost_ff);
            push_word.elapsed_s = el_in;
            push_word.last = 1'b0;
            sl_in = sl_ff; rl_in = rl_ff; lact_in = lact_ff;
            if (lact_ff && msn >= loff_ff) begin
               // lamps cleared anyway at end of report
               lact_in = 1'b0;
            end
            el_in = el_in;
         end else begin
            push_word.size_lamp = sl_in;
            push_word.reject_lamp = rl_in;
            push_word.lost_count = clamp(lost_in);
            push_word.elapsed_s = el_in;
            push_word.last = 1'b1;
         end
      end
   end

   logic unused_ok;
   assign unused_ok = qstat.empty;
   logic unused_sink;
   assign unused_sink = act_n ^ stat ^ unused_ok;
endmodule
`default_nettype wire

// ===== hw/rtl/css_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_queue
// Four-entry word queue between the front and the result port.
// ----------------------------------------------------------------------------
module css_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire css_pkg::word_type    push_word,
   output css_pkg::qstat_type        qstat,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output css_pkg::word_type         rsp_word
);
   css_pkg::word_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic pop;

   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_word = mem_ff[rp_ff];
   assign qstat.room = (cnt_ff != 3'd4);
   assign qstat.empty = (cnt_ff == 3'd0);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/conveyor_size_sorter_fsm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conveyor_size_sorter_fsm_core
// Conveyor sorting controller: sorter state machine feeding a result queue.
// ----------------------------------------------------------------------------
// A result word enters the queue when its item is taken, then drains to rsp_.
// One item per cycle when ready; a report busies the front for two more words.
// A full four-word queue holds off req_ready until the port drains.
// Reset (synchronous): mode idle, counters and lamps clear, registers default.
module conveyor_size_sorter_fsm_core #(
   parameter int COUNT_WIDTH = 16,
   parameter int MS_WIDTH    = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [11:0] req_light_sample,
   input  wire logic [11:0] req_size_sample,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_mode,
   output logic             rsp_status_lamp,
   output logic [1:0]       rsp_size_lamp,
   output logic             rsp_reject_lamp,
   output logic [2:0]       rsp_event_res,
   output logic [1:0]       rsp_size_class,
   output logic [15:0]      rsp_accepted_count,
   output logic [15:0]      rsp_rejected_count,
   output logic [15:0]      rsp_lost_count,
   output logic [15:0]      rsp_elapsed_s,
   output logic             rsp_last
);
   css_pkg::qstat_type qstat;
   css_pkg::word_type  pw, rw;
   logic push;

   assign csr_ready = 1'b1;

   css_front #(.COUNT_WIDTH(COUNT_WIDTH), .MS_WIDTH(MS_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_light_sample,
      .req_size_sample, .csr_valid, .csr_index, .csr_data, .qstat,
      .push, .push_word(pw)
   );

   css_queue u_queue (
      .clock, .reset, .push, .push_word(pw), .qstat,
      .rsp_valid, .rsp_ready, .rsp_word(rw)
   );

   assign rsp_mode = rw.mode;
   assign rsp_status_lamp = rw.status_lamp;
   assign rsp_size_lamp = rw.size_lamp;
   assign rsp_reject_lamp = rw.reject_lamp;
   assign rsp_event_res = rw.event_res;
   assign rsp_size_class = rw.size_class;
   assign rsp_accepted_count = rw.accepted_count;
   assign rsp_rejected_count = rw.rejected_count;
   assign rsp_lost_count = rw.lost_count;
   assign rsp_elapsed_s = rw.elapsed_s;
   assign rsp_last = rw.last;
endmodule
`default_nettype wire

// ===== hw/rtl/css_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks of the conveyor sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "conveyor_size_sorter_fsm_core_assert.svh"
module css_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_event_res,
   input wire logic [1:0] rsp_size_class,
   input wire logic       rsp_last
);
   `CSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CSS_ASSERT_IMPL(a_cls_range, clock, reset, rsp_valid, rsp_size_class != 2'd3)
   `CSS_ASSERT_IMPL(a_report_first, clock, reset, rsp_valid && rsp_event_res == css_pkg::EV_REPORT && rsp_size_class == 2'd0, !rsp_last)
   `CSS_ASSERT_IMPL(a_nonrep_last, clock, reset, rsp_valid && rsp_event_res != css_pkg::EV_REPORT, rsp_last)
   `CSS_ASSERT_NEXT(a_first_rst, clock, reset, $fell(reset), !rsp_valid)
endmodule

bind conveyor_size_sorter_fsm_core css_checker u_css_checker (
   .clock, .reset, .rsp_valid, .rsp_ready,
   .rsp_event_res, .rsp_size_class, .rsp_last
);
`default_nettype wire
